// ===== hw/rtl/circular_queue_with_delete_macros.svh =====
// Assertion macros for the circular queue with delete.
// Relies on clk and rst being in scope where a macro is used.
`ifndef CIRCULAR_QUEUE_WITH_DELETE_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_DELETE_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold at every edge out of reset.
`define CQD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Consequent must hold in the same cycle as the antecedent.
`define CQD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define CQD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CQD_ASSERT_ALWAYS(lbl, cond, msg)
`define CQD_ASSERT_SAME(lbl, ante, cons, msg)
`define CQD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/cqd_pkg.sv =====
// Shared types, codes and slot arithmetic for the circular queue with delete.
// No dependencies.
`default_nettype none
package cqd_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int OCC_W      = $clog2(DEPTH + 1);
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int TDATA_W    = ((WORD_WIDTH + OCC_W + 7) / 8) * 8;

  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [OCC_W-1:0]           occ_t;
  typedef logic signed [WORD_WIDTH-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ  = 3'd0,
    CMD_DEQ  = 3'd1,
    CMD_PEEK = 3'd2,
    CMD_DEL  = 3'd3,
    CMD_DISP = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    status_t status;
    word_t   data;
    occ_t    occupancy;
    logic    last;
  } result_t;

  // Step one slot forward, wrapping at the configured capacity.
  function automatic slot_t slot_next(slot_t s, occ_t cap);
    occ_t s1;
    s1 = occ_t'(s) + occ_t'(1);
    return (s1 >= cap) ? '0 : s1[SLOT_W-1:0];
  endfunction

  // Step one slot back, wrapping at the configured capacity.
  function automatic slot_t slot_prev(slot_t s, occ_t cap);
    occ_t c1;
    c1 = cap - occ_t'(1);
    return (s == '0) ? c1[SLOT_W-1:0] : s - slot_t'(1);
  endfunction

  // Clamp a written capacity into 1..DEPTH.
  function automatic occ_t cap_clamp(occ_t v);
    if (v == '0) return occ_t'(1);
    if (v > occ_t'(DEPTH)) return occ_t'(DEPTH);
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cqd_out_reg.sv =====
// Output holding register for result items of the circular queue.
// Depends on cqd_pkg for result_t and field widths.
`default_nettype none
module cqd_out_reg
  import cqd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  result_t             res,
  output logic                free,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TDATA_W-1:0]  m_axis_tdata,  // data, occupancy, zero pad
  output logic [STATUS_W-1:0] m_axis_tuser,  // status
  output logic                m_axis_tlast
);

  result_t held;
  logic    valid;

  assign free = !valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (push && free) begin
      valid <= 1'b1;
    end else if (m_axis_tready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push && free) begin
      held <= res;
    end
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tdata  = TDATA_W'({held.occupancy, held.data});
  assign m_axis_tuser  = held.status;
  assign m_axis_tlast  = held.last;

endmodule
`default_nettype wire

// ===== hw/rtl/circular_queue_with_delete.sv =====
// Top level of the circular queue with delete: control sequencer and word store.
// Depends on cqd_pkg, cqd_out_reg and circular_queue_with_delete_macros.svh.
`default_nettype none
`include "circular_queue_with_delete_macros.svh"
// Ring-buffer queue of signed 32-bit words held in a 16-entry single-port-read
// store with a registered read. One request item is worked at a time.
// Enqueue, dequeue, peek and unknown commands first accept the item and start
// the read of the head slot, then act and hand the result to the output
// register. Display then hands on the stored words from the head, giving one
// result item a cycle while the output side keeps up. Delete compares words
// from the head during the search, then moves each later word one slot toward
// the head and finishes; a delete that finds no match ends after the last
// word compared, and delete or display on an empty queue ends in its act
// step. The single read port of the store sets both walks. A result
// waiting at the output holds up only the sequencer, never the result already
// presented. A capacity write (legal only while idle) empties the queue at
// once; the store itself has no reset and no clearing pass, since only slots
// between head and tail are ever read.
module circular_queue_with_delete
  import cqd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [OCC_W-1:0]    cfg_wdata,     // capacity
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [WORD_WIDTH-1:0] s_axis_tdata, // value
  input  logic [CMD_W-1:0]    s_axis_tuser,  // cmd
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TDATA_W-1:0]  m_axis_tdata,  // data, occupancy, zero pad
  output logic [STATUS_W-1:0] m_axis_tuser,  // status
  output logic                m_axis_tlast
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OP,
    S_SEARCH,
    S_SHIFT,
    S_DEL_FIN,
    S_DISP
  } state_t;

  // Sequencer registers and their next values.
  state_t state, state_next;
  slot_t  head_slot, head_slot_next;
  slot_t  tail_slot, tail_slot_next;
  logic   is_empty, is_empty_next;
  occ_t   occ, occ_next;
  occ_t   cap, cap_next;
  slot_t  idx, idx_next;
  logic [CMD_W-1:0] cmd_q, cmd_q_next;
  word_t  value_q, value_q_next;

  // Word store: one write and one registered read per cycle.
  word_t store [DEPTH];
  word_t rdata;
  logic  rd_en, wr_en;
  slot_t rd_addr, wr_addr;
  word_t wr_data;

  // Result hand-off.
  logic    push, out_free;
  result_t res;

  slot_t idx_nxt;
  logic  match;

  assign s_axis_tready = (state == S_IDLE) && !cfg_we;
  assign idx_nxt       = slot_next(idx, cap);
  assign match         = (rdata == value_q);

  always_comb begin
    state_next     = state;
    head_slot_next = head_slot;
    tail_slot_next = tail_slot;
    is_empty_next  = is_empty;
    occ_next       = occ;
    cap_next       = cap;
    idx_next       = idx;
    cmd_q_next     = cmd_q;
    value_q_next   = value_q;
    rd_en          = 1'b0;
    rd_addr        = head_slot;
    wr_en          = 1'b0;
    wr_addr        = idx;
    wr_data        = rdata;
    push           = 1'b0;
    res.status     = ST_OK;
    res.data       = '0;
    res.occupancy  = occ;
    res.last       = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (cfg_we) begin
          // Capacity write: clamp and empty the ring.
          cap_next       = cap_clamp(cfg_wdata);
          head_slot_next = '0;
          tail_slot_next = '0;
          is_empty_next  = 1'b1;
          occ_next       = '0;
        end else if (s_axis_tvalid) begin
          // Latch the item and start the head read for every command.
          cmd_q_next   = s_axis_tuser;
          value_q_next = word_t'(s_axis_tdata);
          rd_en        = 1'b1;
          rd_addr      = head_slot;
          state_next   = S_OP;
        end
      end

      S_OP: begin
        case (cmd_q)
          CMD_ENQ: begin
            if (out_free) begin
              push       = 1'b1;
              state_next = S_IDLE;
              if (occ >= cap) begin
                res.status = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_data = value_q;
                if (is_empty) begin
                  head_slot_next = '0;
                  tail_slot_next = '0;
                  wr_addr        = '0;
                end else begin
                  tail_slot_next = slot_next(tail_slot, cap);
                  wr_addr        = slot_next(tail_slot, cap);
                end
                is_empty_next = 1'b0;
                occ_next      = occ + occ_t'(1);
                res.occupancy = occ + occ_t'(1);
              end
            end
          end
          CMD_DEQ: begin
            if (out_free) begin
              push       = 1'b1;
              state_next = S_IDLE;
              if (is_empty) begin
                res.status = ST_EMPTY;
              end else begin
                res.data = rdata;
                if (head_slot == tail_slot) begin
                  head_slot_next = '0;
                  tail_slot_next = '0;
                  is_empty_next  = 1'b1;
                end else begin
                  head_slot_next = slot_next(head_slot, cap);
                end
                occ_next      = occ - occ_t'(1);
                res.occupancy = occ - occ_t'(1);
              end
            end
          end
          CMD_PEEK: begin
            if (out_free) begin
              push       = 1'b1;
              state_next = S_IDLE;
              if (is_empty) res.status = ST_EMPTY;
              else          res.data   = rdata;
            end
          end
          CMD_DEL: begin
            if (is_empty) begin
              if (out_free) begin
                push       = 1'b1;
                res.status = ST_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              // Head word is already in rdata: go straight to compare.
              idx_next   = head_slot;
              state_next = S_SEARCH;
            end
          end
          CMD_DISP: begin
            if (is_empty) begin
              if (out_free) begin
                push       = 1'b1;
                res.status = ST_EMPTY;
                state_next = S_IDLE;
              end
            end else begin
              idx_next   = head_slot;
              state_next = S_DISP;
            end
          end
          default: begin
            // Unknown command: plain acknowledge, state untouched.
            if (out_free) begin
              push       = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end

      S_SEARCH: begin
        if (match) begin
          if (idx == tail_slot) begin
            state_next = S_DEL_FIN;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = idx_nxt;
            state_next = S_SHIFT;
          end
        end else if (idx == tail_slot) begin
          if (out_free) begin
            push       = 1'b1;
            res.status = ST_NOT_FOUND;
            state_next = S_IDLE;
          end
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx_nxt;
          idx_next = idx_nxt;
        end
      end

      S_SHIFT: begin
        // Move the later word one slot toward the head, fetch the next one.
        wr_en    = 1'b1;
        wr_addr  = idx;
        wr_data  = rdata;
        idx_next = idx_nxt;
        if (idx_nxt == tail_slot) begin
          state_next = S_DEL_FIN;
        end else begin
          rd_en   = 1'b1;
          rd_addr = slot_next(idx_nxt, cap);
        end
      end

      S_DEL_FIN: begin
        if (out_free) begin
          push = 1'b1;
          if (head_slot == tail_slot) begin
            head_slot_next = '0;
            tail_slot_next = '0;
            is_empty_next  = 1'b1;
          end else begin
            tail_slot_next = slot_prev(tail_slot, cap);
          end
          occ_next      = occ - occ_t'(1);
          res.occupancy = occ - occ_t'(1);
          state_next    = S_IDLE;
        end
      end

      S_DISP: begin
        // One stored word per result; rdata holds while the output is busy.
        if (out_free) begin
          push     = 1'b1;
          res.data = rdata;
          res.last = (idx == tail_slot);
          if (idx == tail_slot) begin
            state_next = S_IDLE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = idx_nxt;
            idx_next = idx_nxt;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_slot <= '0;
      tail_slot <= '0;
      is_empty  <= 1'b1;
      occ       <= '0;
      cap       <= occ_t'(DEPTH);
    end else begin
      state     <= state_next;
      head_slot <= head_slot_next;
      tail_slot <= tail_slot_next;
      is_empty  <= is_empty_next;
      occ       <= occ_next;
      cap       <= cap_next;
    end
  end

  // Working payload registers need no reset.
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    cmd_q   <= cmd_q_next;
    value_q <= value_q_next;
  end

  // Store: read address and write address never collide in one cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= store[rd_addr];
    end
  end

  cqd_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .res           (res),
    .free          (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Count matches empty flag, count <= cap, slots in ring, one item in flight.
  `CQD_ASSERT_ALWAYS(a_empty_occ, (is_empty == (occ == '0)), "empty flag and count disagree")
  `CQD_ASSERT_ALWAYS(a_occ_cap, (occ <= cap), "occupancy above capacity")
  `CQD_ASSERT_SAME(a_ptr_range, !is_empty, (head_slot < cap) && (tail_slot < cap), "slot out of ring")
  `CQD_ASSERT_NEXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken")

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for circular_queue_with_delete: a mirror of the ring queue
// predicts every result item and checks the stream seen on the output side.
// Depends on cqd_pkg and the circular_queue_with_delete RTL only.
module tb_top;
  import cqd_pkg::*;

  // Command codes beyond display are unused; the block must answer them as no-ops.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = CMD_W'(CMD_DISP + 1);
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = '1;
  localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam word_t WORD_ONES = '1;
  localparam int POOL_SIZE = 6;
  // Quiet spell after the last result, longer than a full delete walk.
  localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int DRAIN_LIMIT = 20000;
  localparam int MAX_PRINTED = 30;

  // Mirror of the ring queue: same slots, same wrap rule, same capacity.
  class ring_queue_mirror;
    word_t   ring[DEPTH];
    int      head;
    int      tail;
    int      cap;
    bit      empty;
    result_t due_q[$];
    int      mismatches;
    int      checked;
    int      requests[1 << CMD_W];
    int      n_full;
    int      n_empty;
    int      n_not_found;
    int      deepest;

    function new();
      foreach (ring[k]) ring[k] = '0;
      cap = DEPTH;
      flush();
    endfunction

    function void flush();
      head = 0;
      tail = 0;
      empty = 1'b1;
    endfunction

    // Capacity write: clamp into 1..DEPTH and forget the contents.
    function void set_capacity(logic [OCC_W-1:0] v);
      if (v == '0) cap = 1;
      else if (v > DEPTH) cap = DEPTH;
      else cap = v;
      flush();
    endfunction

    function int stored();
      if (empty) return 0;
      return ((tail + cap - head) % cap) + 1;
    endfunction

    function int step_on(int s);
      return (s + 1 >= cap) ? 0 : s + 1;
    endfunction

    function void expect_result(status_t s, word_t d, logic fin);
      result_t r;
      r.status = s;
      r.data = d;
      r.occupancy = occ_t'(stored());
      r.last = fin;
      due_q.push_back(r);
      if (s == ST_FULL) n_full++;
      if (s == ST_EMPTY) n_empty++;
      if (s == ST_NOT_FOUND) n_not_found++;
    endfunction

    // Work out the result items caused by one accepted request.
    function void accept_request(logic [CMD_W-1:0] c, word_t v);
      int  i;
      int  nx;
      bit  found;
      bit  done;
      requests[c]++;
      case (c)
        CMD_ENQ: begin
          if (!empty && stored() >= cap) begin
            expect_result(ST_FULL, '0, 1'b1);
          end else begin
            if (empty) begin
              head = 0;
              tail = 0;
              empty = 1'b0;
            end else begin
              tail = step_on(tail);
            end
            ring[tail] = v;
            expect_result(ST_OK, '0, 1'b1);
          end
        end
        CMD_DEQ: begin
          if (empty) begin
            expect_result(ST_EMPTY, '0, 1'b1);
          end else begin
            i = head;
            if (head == tail) flush();
            else head = step_on(head);
            expect_result(ST_OK, ring[i], 1'b1);
          end
        end
        CMD_PEEK: begin
          if (empty) expect_result(ST_EMPTY, '0, 1'b1);
          else expect_result(ST_OK, ring[head], 1'b1);
        end
        CMD_DEL: begin
          if (empty) begin
            expect_result(ST_EMPTY, '0, 1'b1);
          end else begin
            i = head;
            found = 1'b0;
            done = 1'b0;
            while (!done) begin
              if (ring[i] == v) begin
                found = 1'b1;
                done = 1'b1;
              end else if (i == tail) begin
                done = 1'b1;
              end else begin
                i = step_on(i);
              end
            end
            if (!found) begin
              expect_result(ST_NOT_FOUND, '0, 1'b1);
            end else begin
              // Close the gap: every later word moves one slot toward the head.
              while (i != tail) begin
                nx = step_on(i);
                ring[i] = ring[nx];
                i = nx;
              end
              if (tail == head) flush();
              else tail = (tail == 0) ? cap - 1 : tail - 1;
              expect_result(ST_OK, '0, 1'b1);
            end
          end
        end
        CMD_DISP: begin
          if (empty) begin
            expect_result(ST_EMPTY, '0, 1'b1);
          end else begin
            i = head;
            done = 1'b0;
            while (!done) begin
              done = (i == tail);
              expect_result(ST_OK, ring[i], done);
              i = step_on(i);
            end
          end
        end
        default: expect_result(ST_OK, '0, 1'b1);
      endcase
      if (stored() > deepest) deepest = stored();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Compare one accepted result item with the oldest expectation.
    task check_response(logic [STATUS_W-1:0] st, logic [TDATA_W-1:0] td, logic fin);
      result_t want;
      word_t   got_data;
      occ_t    got_occ;
      got_data = td[WORD_WIDTH-1:0];
      got_occ = td[WORD_WIDTH +: OCC_W];
      if (due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d data %0h", st, got_data));
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (st !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
      if (got_data !== want.data)
        report_mismatch($sformatf("data %0h, expected %0h", got_data, want.data));
      if (got_occ !== want.occupancy)
        report_mismatch($sformatf("occupancy %0d, expected %0d", got_occ, want.occupancy));
      if (fin !== want.last)
        report_mismatch($sformatf("last %b, expected %b", fin, want.last));
      if (td[TDATA_W-1:WORD_WIDTH+OCC_W] !== '0)
        report_mismatch($sformatf("pad bits %0h not zero", td[TDATA_W-1:WORD_WIDTH+OCC_W]));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [OCC_W-1:0]      cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [WORD_WIDTH-1:0] s_axis_tdata;   // value
  logic [CMD_W-1:0]      s_axis_tuser;   // cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TDATA_W-1:0]    m_axis_tdata;   // data, occupancy, zero pad
  logic [STATUS_W-1:0]   m_axis_tuser;   // status
  logic                  m_axis_tlast;

  ring_queue_mirror mirror = new();

  // Pacing knobs shared by the driving processes.
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_left = 0;
  word_t word_pool[POOL_SIZE];

  circular_queue_with_delete dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one request item, idling first at the current rate, and hold it until
  // the block takes it. Valid stays high afterwards so back-to-back items need
  // no second assignment in the same step; the next idle cycle drops it.
  task automatic send_item(input logic [CMD_W-1:0] c, input word_t v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= $urandom;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c;
    s_axis_tdata <= v;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    mirror.accept_request(c, v);
  endtask

  // Wait until every predicted item has arrived, then idle for a settle spell.
  // Anything still owed after a generous wait is a lost result.
  task automatic wait_drained();
    int n;
    n = 0;
    while (mirror.due_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (mirror.due_q.size() != 0) begin
      mirror.report_mismatch($sformatf("%0d result items never arrived",
                                       mirror.due_q.size()));
      mirror.due_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write while idle; the queue empties on the same edge.
  task automatic write_capacity(input logic [OCC_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    mirror.set_capacity(v);
  endtask

  // A small pool of words makes duplicates common, so deletes mostly hit.
  task automatic refill_pool();
    foreach (word_pool[k]) word_pool[k] = word_t'($urandom);
  endtask

  function automatic word_t pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return word_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (r < 70) return WORD_MAX;
    if (r < 75) return WORD_MIN;
    if (r < 78) return '0;
    if (r < 81) return WORD_ONES;
    return word_t'($urandom);
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input int enq_pct);
    int r;
    if ($urandom_range(0, 99) < enq_pct) return CMD_ENQ;
    r = $urandom_range(0, 99);
    if (r < 30) return CMD_DEQ;
    if (r < 45) return CMD_PEEK;
    if (r < 75) return CMD_DEL;
    if (r < 92) return CMD_DISP;
    return CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
  endfunction

  // One random phase: fresh capacity, fresh pacing, then a run of requests.
  task automatic run_phase(input logic [OCC_W-1:0] cap_word, input int idle_pct,
                           input int stall_pct, input int enq_pct, input int n_items,
                           input int hold_cycles);
    int               k;
    logic [CMD_W-1:0] c;
    word_t            v;
    wait_drained();
    write_capacity(cap_word);
    refill_pool();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    hold_left = hold_cycles;
    for (k = 0; k < n_items; k++) begin
      c = pick_cmd(enq_pct);
      if (c == CMD_DEL && $urandom_range(0, 99) < 25) v = word_t'($urandom);
      else v = pick_word();
      send_item(c, v);
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Output side: check every accepted item, then decide the next ready.
  // A pending hold-off is counted down here and overrides the random stalls.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        mirror.check_response(m_axis_tuser, m_axis_tdata, m_axis_tlast);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int c;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every command on an empty queue, the unused codes, the word
    // extremes, a delete in the middle, a miss, a delete of the head, then
    // drain to empty.
    send_item(CMD_PEEK, '0);
    send_item(CMD_DEQ, '0);
    send_item(CMD_DEL, '0);
    send_item(CMD_DISP, '0);
    for (c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++) send_item(CMD_W'(c), WORD_ONES);
    send_item(CMD_ENQ, WORD_MAX);
    send_item(CMD_ENQ, WORD_MIN);
    send_item(CMD_ENQ, '0);
    send_item(CMD_ENQ, WORD_ONES);
    send_item(CMD_DISP, '0);
    send_item(CMD_DEL, '0);
    send_item(CMD_DEL, word_t'(12345));
    send_item(CMD_DEL, WORD_MAX);
    send_item(CMD_PEEK, '0);
    send_item(CMD_DEQ, '0);
    send_item(CMD_DEQ, '0);
    s_axis_tvalid <= 1'b0;

    // Capacity written as zero behaves as a single slot: fill, overflow, remove.
    wait_drained();
    write_capacity('0);
    send_item(CMD_ENQ, word_t'(5));
    send_item(CMD_ENQ, word_t'(6));
    send_item(CMD_DISP, '0);
    send_item(CMD_DEL, word_t'(5));
    send_item(CMD_DISP, '0);
    s_axis_tvalid <= 1'b0;

    // Random phases across capacities and pacing; writes above DEPTH saturate.
    run_phase(OCC_W'(DEPTH), 0, 0, 60, 30, 0);
    run_phase(OCC_W'(3), 86, 0, 45, 25, 0);
    run_phase(OCC_W'(DEPTH + 1), 0, 86, 50, 30, 0);
    run_phase(OCC_W'(2), 9, 9, 45, 25, 0);
    // Hold the output off long enough that the block backs up onto its input.
    run_phase('1, 0, 0, 55, 25, 300);
    run_phase(OCC_W'(5), 0, 0, 50, 25, 0);
    wait_drained();

    $display("Covered %0d requests: %0d enq, %0d deq, %0d peek, %0d delete, %0d display",
             mirror.requests.sum(), mirror.requests[CMD_ENQ], mirror.requests[CMD_DEQ],
             mirror.requests[CMD_PEEK], mirror.requests[CMD_DEL], mirror.requests[CMD_DISP]);
    $display("%0d result items checked; %0d full, %0d empty, %0d not found, deepest %0d",
             mirror.checked, mirror.n_full, mirror.n_empty, mirror.n_not_found,
             mirror.deepest);
    if (mirror.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mirror.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("Timeout: run did not complete");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
